@@ rtl/bpa_pkg.sv @@
package bpa_pkg;

   // Default geometry of the page map
   localparam int unsigned PAGE_COUNT_DEF = 1048576;
   localparam int unsigned PAGE_BYTES_DEF = 4096;
   localparam int unsigned WORD_BITS_DEF  = 32;

   // Fixed field widths
   localparam int unsigned ADDR_W = 32;
   localparam int unsigned SIZE_W = 33;
   localparam int unsigned CNT_W  = 21;
   // addr + size + page rounding fits here for any page size up to 64 KiB
   localparam int unsigned END_W  = 34;

   typedef enum logic [1:0] {
      ACT_ALLOC     = 2'd0,
      ACT_FREE      = 2'd1,
      ACT_MARK_USED = 2'd2,
      ACT_MARK_FREE = 2'd3
   } action_type;

   // Operation applied to one map word
   typedef enum logic [1:0] {
      WOP_ALLOC = 2'd0,
      WOP_SET   = 2'd1,
      WOP_CLEAR = 2'd2
   } word_op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_WALK,
      ST_DONE
   } engine_state_type;

   typedef struct packed {
      action_type          action;
      logic [ADDR_W-1:0]   addr;
      logic [SIZE_W-1:0]   size;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   page_addr;
      logic                granted;
      logic [CNT_W-1:0]    free_count;
   } rsp_type;

endpackage

@@ rtl/bpa_ram.sv @@
module bpa_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bpa_word.sv @@
module bpa_word #(
   parameter int unsigned WORD_BITS = bpa_pkg::WORD_BITS_DEF,
   parameter int unsigned WS        = $clog2(WORD_BITS)
) (
   input  bpa_pkg::word_op_type op,
   input  logic [WORD_BITS-1:0] data,
   input  logic                 is_first,
   input  logic [WS-1:0]        first_bit,
   input  logic                 is_last,
   input  logic [WS-1:0]        last_bit,
   output logic [WORD_BITS-1:0] new_word,
   output logic [WORD_BITS-1:0] changed,
   output logic                 found,
   output logic [WS-1:0]        bit_idx
);
   import bpa_pkg::*;

   localparam logic [WORD_BITS-1:0] ONES = '1;

   logic [WORD_BITS-1:0] lo_mask;
   logic [WORD_BITS-1:0] hi_mask;
   logic [WORD_BITS-1:0] range_mask;
   logic [WORD_BITS-1:0] free_bits;
   logic [WORD_BITS-1:0] low_free;

   // Build the page mask of this word and isolate the lowest free page
   always_comb begin
      lo_mask    = is_first ? (ONES << first_bit) : ONES;
      // ~last_bit equals WORD_BITS-1-last_bit
      hi_mask    = is_last ? (ONES >> (~last_bit)) : ONES;
      range_mask = lo_mask & hi_mask;
      free_bits  = ~data;
      low_free   = free_bits & (~free_bits + WORD_BITS'(1));
      found      = |free_bits;
      bit_idx    = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         bit_idx = bit_idx | (low_free[i] ? WS'(i) : '0);
      end
   end

   // Apply the word operation
   always_comb begin
      unique case (op)
         WOP_ALLOC: begin
            new_word = data | low_free;
            changed  = low_free;
         end
         WOP_SET: begin
            new_word = data | range_mask;
            changed  = range_mask & ~data;
         end
         WOP_CLEAR: begin
            new_word = data & ~range_mask;
            changed  = range_mask & data;
         end
         default: begin
            new_word = data;
            changed  = '0;
         end
      endcase
   end

endmodule

@@ rtl/bpa_engine.sv @@
module bpa_engine #(
   parameter int unsigned PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
   parameter int unsigned PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF,
   parameter int unsigned WORD_BITS  = bpa_pkg::WORD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bpa_pkg::req_type req_item,
   output logic             done_valid,
   input  logic             done_ack,
   output bpa_pkg::rsp_type done_item
);
   import bpa_pkg::*;

   localparam int unsigned WS        = $clog2(WORD_BITS);
   localparam int unsigned PS        = $clog2(PAGE_BYTES);
   localparam int unsigned MAP_DEPTH = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned MW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int unsigned PTR_W     = MW + 1;
   localparam int unsigned PW        = $clog2(PAGE_COUNT + 1);
   localparam int unsigned LP_W      = ADDR_W - PS;
   localparam int unsigned HP_W      = END_W - PS;
   localparam int unsigned CW        = (HP_W > PW) ? HP_W : PW;
   localparam int unsigned PI_W      = MW + WS;
   localparam int unsigned PA_W      = PI_W + PS;

   localparam logic [MW-1:0]        LAST_WORD  = MW'(MAP_DEPTH - 1);
   localparam logic [CW-1:0]        PAGE_LIMIT = CW'(PAGE_COUNT);
   localparam logic [WORD_BITS-1:0] FULL_WORD  = '1;

   // Population count in six halving steps
   function automatic logic [6:0] ones_count(input logic [63:0] v);
      logic [63:0] s;
      s = v - ((v >> 1) & 64'h5555_5555_5555_5555);
      s = (s & 64'h3333_3333_3333_3333) + ((s >> 2) & 64'h3333_3333_3333_3333);
      s = (s + (s >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
      s = s + (s >> 8);
      s = s + (s >> 16);
      s = s + (s >> 32);
      return s[6:0];
   endfunction

   engine_state_type     state_ff, state_in;
   action_type           action_ff, action_in;
   logic [LP_W-1:0]      lo_ff, lo_in;
   logic [PW-1:0]        hi_ff, hi_in;
   logic [PTR_W-1:0]     ptr_ff, ptr_in;
   logic [MW-1:0]        first_word_ff, first_word_in;
   logic [WS-1:0]        first_bit_ff, first_bit_in;
   logic [MW-1:0]        last_word_ff, last_word_in;
   logic [WS-1:0]        last_bit_ff, last_bit_in;
   logic                 pend_ff, pend_in;
   logic [MW-1:0]        pend_addr_ff, pend_addr_in;
   logic [WORD_BITS-1:0] chg_ff, chg_in;
   logic                 chg_vld_ff, chg_vld_in;
   logic                 chg_set_ff, chg_set_in;
   logic [CNT_W-1:0]     free_total_ff, free_total_in;
   logic [MW-1:0]        hint_ff, hint_in;
   logic [ADDR_W-1:0]    page_addr_ff, page_addr_in;
   logic                 granted_ff, granted_in;

   // Memory port
   logic                 mem_wr_en;
   logic [MW-1:0]        mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data;
   logic                 mem_rd_en;
   logic [WORD_BITS-1:0] mem_rd_data;

   // Word datapath
   word_op_type          op;
   logic [WORD_BITS-1:0] new_word;
   logic [WORD_BITS-1:0] changed;
   logic                 found;
   logic [WS-1:0]        bit_idx;

   // Request decode
   logic [LP_W-1:0]      lo_req;
   logic [END_W-1:0]     round_up;
   logic [END_W-1:0]     end_sum;
   logic [HP_W-1:0]      hi_raw;
   logic [CW-1:0]        hi_ext;
   logic [PW-1:0]        hi_clip;

   // Range setup and allocation result
   logic                 empty;
   logic [PW-1:0]        last_page;
   logic [MW-1:0]        lo_word;
   logic [PI_W-1:0]      page_idx;
   logic                 page_ok;
   logic [PA_W-1:0]      byte_addr;
   logic [6:0]           pc;
   logic [CNT_W-1:0]     pc_ext;

   bpa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_DEPTH),
      .AW    (MW)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (ptr_ff[MW-1:0]),
      .rd_data (mem_rd_data)
   );

   bpa_word #(
      .WORD_BITS (WORD_BITS),
      .WS        (WS)
   ) u_word (
      .op        (op),
      .data      (mem_rd_data),
      .is_first  (pend_addr_ff == first_word_ff),
      .first_bit (first_bit_ff),
      .is_last   (pend_addr_ff == last_word_ff),
      .last_bit  (last_bit_ff),
      .new_word  (new_word),
      .changed   (changed),
      .found     (found),
      .bit_idx   (bit_idx)
   );

   // Map the action onto a word operation
   always_comb begin
      unique case (action_ff) inside
         ACT_ALLOC:                op = WOP_ALLOC;
         ACT_MARK_USED:            op = WOP_SET;
         ACT_FREE, ACT_MARK_FREE:  op = WOP_CLEAR;
      endcase
   end

   // Turn the byte range of the request into a clipped page range
   always_comb begin
      lo_req   = LP_W'(req_item.addr >> PS);
      round_up = (req_item.action == ACT_MARK_USED) ? END_W'(PAGE_BYTES - 1) : '0;
      end_sum  = END_W'(req_item.addr) + END_W'(req_item.size) + round_up;
      hi_raw   = (req_item.action == ACT_FREE) ? (HP_W'(lo_req) + HP_W'(1))
                                               : HP_W'(end_sum >> PS);
      hi_ext   = CW'(hi_raw);
      hi_clip  = (hi_ext > PAGE_LIMIT) ? PW'(PAGE_COUNT) : PW'(hi_ext);
   end

   // Derived range bounds and allocated page
   always_comb begin
      empty     = CW'(lo_ff) >= CW'(hi_ff);
      last_page = hi_ff - PW'(1);
      lo_word   = MW'(lo_ff >> WS);
      page_idx  = {pend_addr_ff, bit_idx};
      page_ok   = {1'b0, page_idx} < (PI_W + 1)'(PAGE_COUNT);
      byte_addr = PA_W'(page_idx) << PS;
      pc        = ones_count(64'(chg_ff));
      pc_ext    = CNT_W'(pc);
   end

   // Next state, memory control and count update
   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      ptr_in        = ptr_ff;
      first_word_in = first_word_ff;
      first_bit_in  = first_bit_ff;
      last_word_in  = last_word_ff;
      last_bit_in   = last_bit_ff;
      chg_in        = chg_ff;
      chg_vld_in    = 1'b0;
      chg_set_in    = chg_set_ff;
      hint_in       = hint_ff;
      page_addr_in  = page_addr_ff;
      granted_in    = granted_ff;
      free_total_in = free_total_ff;
      req_ready     = 1'b0;
      done_valid    = 1'b0;
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = pend_addr_ff;
      mem_wr_data   = new_word;

      // retire the bits changed by the previous word write
      if (chg_vld_ff) begin
         if (chg_set_ff) begin
            free_total_in = (pc_ext >= free_total_ff) ? '0 : free_total_ff - pc_ext;
         end else begin
            free_total_in = free_total_ff + pc_ext;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ptr_ff[MW-1:0];
            mem_wr_data = FULL_WORD;
            if (ptr_ff[MW-1:0] == LAST_WORD) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + PTR_W'(1);
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               action_in = req_item.action;
               lo_in     = lo_req;
               hi_in     = hi_clip;
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            page_addr_in = '0;
            granted_in   = 1'b0;
            if (action_ff == ACT_ALLOC) begin
               if (free_total_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  ptr_in        = {1'b0, hint_ff};
                  first_word_in = hint_ff;
                  first_bit_in  = '0;
                  last_word_in  = LAST_WORD;
                  last_bit_in   = '1;
                  state_in      = ST_WALK;
               end
            end else if (empty) begin
               state_in = ST_DONE;
            end else begin
               ptr_in        = {1'b0, lo_word};
               first_word_in = lo_word;
               first_bit_in  = lo_ff[WS-1:0];
               last_word_in  = MW'(last_page >> WS);
               last_bit_in   = last_page[WS-1:0];
               // freed pages may sit below the scan start
               if (action_ff != ACT_MARK_USED && lo_word < hint_ff) begin
                  hint_in = lo_word;
               end
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // read ahead one word while the previous one is written back
            mem_rd_en = ptr_ff <= {1'b0, last_word_ff};
            if (mem_rd_en) begin
               ptr_in = ptr_ff + PTR_W'(1);
            end
            if (pend_ff) begin
               if (op == WOP_ALLOC) begin
                  if (found) begin
                     if (page_ok) begin
                        mem_wr_en     = 1'b1;
                        granted_in    = 1'b1;
                        page_addr_in  = ADDR_W'(byte_addr);
                        free_total_in = free_total_ff - CNT_W'(1);
                        hint_in       = pend_addr_ff;
                     end
                     state_in = ST_DONE;
                  end else if (pend_addr_ff == last_word_ff) begin
                     state_in = ST_DONE;
                  end
               end else begin
                  mem_wr_en  = 1'b1;
                  chg_in     = changed;
                  chg_vld_in = 1'b1;
                  chg_set_in = (op == WOP_SET);
                  if (pend_addr_ff == last_word_ff) begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_DONE: begin
            // hold until the last count update has landed
            done_valid = !chg_vld_ff;
            if (done_valid && done_ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign pend_in      = mem_rd_en;
   assign pend_addr_in = ptr_ff[MW-1:0];

   always_comb begin
      done_item.page_addr  = page_addr_ff;
      done_item.granted    = granted_ff;
      done_item.free_count = free_total_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         ptr_ff        <= '0;
         pend_ff       <= 1'b0;
         chg_vld_ff    <= 1'b0;
         free_total_ff <= '0;
         hint_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         pend_ff       <= pend_in;
         chg_vld_ff    <= chg_vld_in;
         free_total_ff <= free_total_in;
         hint_ff       <= hint_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      first_word_ff <= first_word_in;
      first_bit_ff  <= first_bit_in;
      last_word_ff  <= last_word_in;
      last_bit_ff   <= last_bit_in;
      pend_addr_ff  <= pend_addr_in;
      chg_ff        <= chg_in;
      chg_set_ff    <= chg_set_in;
      page_addr_ff  <= page_addr_in;
      granted_ff    <= granted_in;
   end

   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != ptr_ff[MW-1:0]))
      else $error("map read and write hit the same word");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      free_total_ff <= CNT_W'(PAGE_COUNT))
      else $error("free count exceeds page count");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!chg_vld_ff && !pend_ff))
      else $error("map access still in flight while idle");

   a_grant_alloc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && granted_ff) |-> (action_ff == ACT_ALLOC))
      else $error("grant reported for a non-allocate transaction");

endmodule

@@ rtl/bitmap_page_allocator.sv @@
// Allocate visits words from the lowest word that may hold a free page up to the first one
// that does; free-page and range actions visit every word touched, and their last count
// update settles first. Allocate with no free page and empty ranges visit no map word.
// One transaction at a time, the next request taken in the cycle after the result loads.
// Reset clears the count and fills the map, req_ready low.
module bitmap_page_allocator #(
   parameter int unsigned PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
   parameter int unsigned PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF,
   parameter int unsigned WORD_BITS  = bpa_pkg::WORD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bpa_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bpa_pkg::rsp_type rsp_item
);
   import bpa_pkg::*;

   logic    done_valid;
   logic    done_ack;
   rsp_type done_item;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff, rsp_item_in;

   bpa_engine #(
      .PAGE_COUNT (PAGE_COUNT),
      .PAGE_BYTES (PAGE_BYTES),
      .WORD_BITS  (WORD_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .done_valid (done_valid),
      .done_ack   (done_ack),
      .done_item  (done_item)
   );

   // Load the output register when it is empty or being drained
   always_comb begin
      done_ack     = done_valid && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (done_ack) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = done_item;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

@@ bench/bitmap_page_allocator_tb.sv @@
module bitmap_page_allocator_tb;
   import bpa_pkg::*;

   localparam int unsigned PAGE_COUNT = PAGE_COUNT_DEF;
   localparam int unsigned PAGE_BYTES = PAGE_BYTES_DEF;
   localparam int unsigned WORD_BITS  = WORD_BITS_DEF;
   localparam int unsigned MAP_WORDS  = PAGE_COUNT / WORD_BITS;
   localparam int unsigned RANDOM_REQS = 550;
   // Low pages that most random traffic stays in, so allocation scans stay short
   localparam int unsigned HOT_PAGES  = 256;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   // Expected state of the page map
   logic [WORD_BITS-1:0] usage_words [MAP_WORDS];
   longint unsigned      spare_pages;

   req_type req_backlog[$];
   rsp_type predicted_rsps[$];

   int total_reqs     = 0;
   int accepted_reqs  = 0;
   int error_count    = 0;
   int req_wait       = 0;
   int req_quiet      = 0;
   int rsp_stall      = 0;
   int rsp_quiet      = 0;
   int rsp_seen       = 0;
   int long_hold      = 0;
   bit long_hold_done = 1'b0;

   bitmap_page_allocator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always #4 clock = ~clock;

   // Draw the idle cycles before the next transaction, with runs of back-to-back ones
   function automatic int draw_gap(inout int quiet_left);
      if (quiet_left != 0) begin
         quiet_left = quiet_left - 1;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         quiet_left = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   // Set or clear the bits of pages [lo, hi) and return how many actually changed
   function automatic longint unsigned update_range(longint unsigned lo, longint unsigned hi,
                                                    bit set_used);
      longint unsigned changed;
      longint unsigned w;
      longint unsigned first;
      longint unsigned last;
      logic [WORD_BITS-1:0] mask;
      changed = 0;
      if (hi > PAGE_COUNT)
         hi = PAGE_COUNT;
      if (lo < hi) begin
         for (w = lo / WORD_BITS; w * WORD_BITS < hi; w++) begin
            first = (lo > w * WORD_BITS) ? lo - w * WORD_BITS : 0;
            last  = (hi < (w + 1) * WORD_BITS) ? hi - w * WORD_BITS : WORD_BITS;
            mask  = (32'hFFFFFFFF << first) & (32'hFFFFFFFF >> (WORD_BITS - last));
            if (set_used) begin
               changed += $countones(mask & ~usage_words[w]);
               usage_words[w] = usage_words[w] | mask;
            end else begin
               changed += $countones(mask & usage_words[w]);
               usage_words[w] = usage_words[w] & ~mask;
            end
         end
      end
      return changed;
   endfunction

   // Apply one request to the expected map and return the result it should give
   function automatic rsp_type predict_action(req_type r);
      rsp_type         res;
      longint unsigned start;
      longint unsigned span;
      longint unsigned page;
      longint unsigned changed;
      longint unsigned w;
      longint unsigned b;
      bit              found;
      res   = '0;
      start = r.addr;
      span  = r.size;
      page  = start / PAGE_BYTES;
      case (r.action)
         ACT_ALLOC: begin
            found = 1'b0;
            if (spare_pages != 0) begin
               for (w = 0; w < MAP_WORDS && !found; w++) begin
                  if (usage_words[w] != 32'hFFFFFFFF) begin
                     for (b = 0; b < WORD_BITS && !found; b++) begin
                        if (!usage_words[w][b]) begin
                           found = 1'b1;
                           usage_words[w][b] = 1'b1;
                           spare_pages = spare_pages - 1;
                           res.page_addr = ADDR_W'((w * WORD_BITS + b) * PAGE_BYTES);
                           res.granted = 1'b1;
                        end
                     end
                  end
               end
            end
         end
         ACT_FREE: begin
            if (page < PAGE_COUNT && usage_words[page / WORD_BITS][page % WORD_BITS]) begin
               usage_words[page / WORD_BITS][page % WORD_BITS] = 1'b0;
               spare_pages = spare_pages + 1;
            end
         end
         ACT_MARK_USED: begin
            changed = update_range(page, (start + span + PAGE_BYTES - 1) / PAGE_BYTES, 1'b1);
            spare_pages = (changed >= spare_pages) ? 0 : spare_pages - changed;
         end
         default: begin
            changed = update_range(page, (start + span) / PAGE_BYTES, 1'b0);
            spare_pages = spare_pages + changed;
         end
      endcase
      spare_pages = spare_pages & ((64'd1 << CNT_W) - 1);
      res.free_count = CNT_W'(spare_pages);
      return res;
   endfunction

   task automatic add_req(action_type act, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s);
      req_type r;
      r.action = act;
      r.addr   = a;
      r.size   = s;
      req_backlog.push_back(r);
      total_reqs++;
   endtask

   task automatic report_field(string field, longint unsigned exp_val, longint unsigned act_val);
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, exp_val, act_val);
      error_count++;
   endtask

   // Driver: present the next request once the previous one is taken and its gap is over
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_rsps.push_back(predict_action(req_item));
            accepted_reqs++;
            req_wait = draw_gap(req_quiet);
         end else if (!req_valid && req_wait != 0) begin
            req_wait = req_wait - 1;
         end
         if (!req_valid || req_ready) begin
            if (req_wait == 0 && req_backlog.size() != 0) begin
               req_item  <= req_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result against the oldest prediction and pace rsp_ready
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsps.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual 0x%0h", $time, rsp_item);
               error_count++;
            end else begin
               exp_rsp = predicted_rsps.pop_front();
               if (rsp_item.page_addr !== exp_rsp.page_addr)
                  report_field("page_addr", exp_rsp.page_addr, rsp_item.page_addr);
               if (rsp_item.granted !== exp_rsp.granted)
                  report_field("granted", exp_rsp.granted, rsp_item.granted);
               if (rsp_item.free_count !== exp_rsp.free_count)
                  report_field("free_count", exp_rsp.free_count, rsp_item.free_count);
            end
            rsp_seen++;
            rsp_stall = draw_gap(rsp_quiet);
         end else if (rsp_stall != 0) begin
            rsp_stall = rsp_stall - 1;
         end
         // Hold off once for a long stretch so the block backs up into its input
         if (rsp_seen == 150 && !long_hold_done) begin
            long_hold      = 500;
            long_hold_done = 1'b1;
         end
         if (long_hold != 0)
            long_hold = long_hold - 1;
         rsp_ready <= (rsp_stall == 0) && (long_hold == 0);
      end
   end

   // Stimulus, reset and end of run
   initial begin
      int unsigned     pick;
      longint unsigned a;
      action_type      act;
      logic [SIZE_W-1:0] s;

      for (int unsigned i = 0; i < MAP_WORDS; i++)
         usage_words[i] = 32'hFFFFFFFF;
      spare_pages = 0;

      // Directed: empty map, top page, whole map, word edges, clipping, empty ranges
      add_req(ACT_ALLOC,     32'h0000_0000, 33'h0_0000_0000);
      add_req(ACT_FREE,      32'hFFFF_FFFF, 33'h1_FFFF_FFFF);
      add_req(ACT_FREE,      32'hFFFF_F000, 33'h0_0000_0000);
      add_req(ACT_ALLOC,     32'h0000_0000, 33'h0_0000_0000);
      add_req(ACT_MARK_FREE, 32'h0000_0000, 33'h1_0000_0000);
      add_req(ACT_ALLOC,     32'h0000_0000, 33'h0_0000_0000);
      add_req(ACT_MARK_FREE, 32'h0000_0001, 33'h0_0000_0000);
      add_req(ACT_MARK_USED, 32'h0000_1000, 33'h0_0000_0001);
      add_req(ACT_MARK_FREE, 32'h0000_1FFF, 33'h0_0000_1001);
      add_req(ACT_MARK_USED, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF);
      add_req(ACT_MARK_USED, 32'h0000_0000, 33'h1_0000_0000);
      add_req(ACT_ALLOC,     32'h0000_0000, 33'h0_0000_0000);
      add_req(ACT_FREE,      32'h0000_0FFF, 33'h0_0000_0000);
      add_req(ACT_MARK_FREE, 32'h0001_0000, 33'h0_0002_0000);
      add_req(ACT_ALLOC,     32'h0000_0000, 33'h0_0000_0000);
      add_req(ACT_ALLOC,     32'h0000_0000, 33'h0_0000_0000);
      add_req(ACT_MARK_FREE, 32'hFFFF_0000, 33'h0_FFFF_FFFF);
      add_req(ACT_MARK_USED, 32'hFFFF_8000, 33'h0_0000_0001);
      add_req(ACT_MARK_USED, 32'hFFFF_0000, 33'h0_0001_0000);
      add_req(ACT_MARK_FREE, 32'h0000_1800, 33'h0_0000_0100);
      add_req(ACT_MARK_USED, 32'h0000_5000, 33'h0_0000_0000);
      add_req(ACT_MARK_USED, 32'h0001_5001, 33'h0_0000_0000);
      add_req(ACT_FREE,      32'h0001_4000, 33'h0_0000_0000);
      add_req(ACT_ALLOC,     32'h0000_0000, 33'h0_0000_0000);

      // Random: mostly the low pages, rarely anywhere, rarely huge ranges
      for (int n = 0; n < RANDOM_REQS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25)
            act = ACT_ALLOC;
         else if (pick < 55)
            act = ACT_FREE;
         else if (pick < 75)
            act = ACT_MARK_USED;
         else
            act = ACT_MARK_FREE;
         if ($urandom_range(0, 31) == 0)
            a = $urandom;
         else
            a = longint'($urandom_range(0, HOT_PAGES - 1)) * PAGE_BYTES
                + $urandom_range(0, PAGE_BYTES - 1);
         if ($urandom_range(0, 63) == 0)
            s = {1'($urandom_range(0, 1)), 32'($urandom)};
         else
            s = SIZE_W'($urandom_range(0, 4 * PAGE_BYTES));
         add_req(act, ADDR_W'(a), s);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (accepted_reqs < total_reqs || predicted_rsps.size() != 0)
         @(posedge clock);
      repeat (64) @(posedge clock);

      if (error_count == 0 && predicted_rsps.size() == 0)
         $display("bitmap_page_allocator test passed");
      else
         $display("bitmap_page_allocator test failed");
      $finish;
   end

   // Watchdog
   initial begin
      #64000000;
      $display("bitmap_page_allocator test failed");
      $finish;
   end

endmodule
